>>> hw/rtl/mts_pkg.sv
`default_nettype none

package mts_pkg;

    localparam int VALUE_W = 32;
    localparam int DEPTH_W = 7;
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 2;

    // Input transfer: command, then value, padded to whole bytes.
    localparam int S_FIELDS_W = CMD_W + VALUE_W;
    localparam int S_DATA_W   = ((S_FIELDS_W + 7) / 8) * 8;

    // Output transfer: top, min, depth, is_empty, status, padded to whole bytes.
    localparam int M_FIELDS_W = 2 * VALUE_W + DEPTH_W + 1 + STAT_W;
    localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

    localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_OVERFLOW  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_UNDERFLOW = 2'd2;

    typedef logic [VALUE_W-1:0] t_word;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic               is_empty;
        logic [DEPTH_W-1:0] depth;
        t_word              min_value;
        t_word              top_value;
    } t_result;

    // One stack entry: its value and the minimum of everything at or below it.
    typedef struct packed {
        t_word min_value;
        t_word value;
    } t_entry;

endpackage

`default_nettype wire

>>> hw/rtl/min_tracking_stack.sv
`default_nettype none

// Channel   Dir  Handshake                     Payload
// s (cmd)   in   i_s_tvalid / o_s_tready       i_s_tdata: command, value
// m (res)   out  o_m_tvalid / i_m_tready       o_m_tdata: top, min, depth, is_empty, status
//
// Push, peek, refused commands and a pop that empties the stack load their result
// into the output registers when taken. A pop that leaves entries behind first passes
// through the memory read state: the new top comes from the registered memory read port.
// The top entry is mirrored in registers, so push never reads the memory.
// Two output registers let a new command be taken while one result still waits.
// Reset clears the entry count and all valid flags; the memory is not cleared.

module min_tracking_stack #(
    parameter int STACK_DEPTH = 64
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_s_tvalid,
    output logic                            o_s_tready,
    // [1:0] command, [33:2] value, [39:34] zero
    input  wire  [mts_pkg::S_DATA_W-1:0]    i_s_tdata,
    output logic                            o_m_tvalid,
    input  wire                             i_m_tready,
    // [31:0] top_value, [63:32] min_value, [70:64] depth, [71] is_empty,
    // [73:72] status, [79:74] zero
    output logic [mts_pkg::M_DATA_W-1:0]    o_m_tdata
);
    import mts_pkg::*;

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    localparam logic S_IDLE   = 1'b0;
    localparam logic S_POP_RD = 1'b1;

    logic               r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    t_word              r_top_val, n_top_val;
    t_word              r_top_min, n_top_min;

    logic               r_out_valid, n_out_valid;
    t_result            r_out_data, n_out_data;
    logic               r_skid_valid, n_skid_valid;
    t_result            r_skid_data, n_skid_data;

    t_entry             mem [STACK_DEPTH];
    t_entry             r_rd_data;
    logic               mem_we;
    logic [AW-1:0]      mem_wa;
    t_entry             mem_wd;
    logic [AW-1:0]      mem_ra;

    logic [CMD_W-1:0]   in_cmd;
    t_word              in_val;
    logic               s_take, m_take;
    logic               res_push;
    t_result            res;
    logic [STAT_W-1:0]  res_status;
    t_word              push_min;
    logic               full, empty;

    assign in_cmd = i_s_tdata[CMD_W-1:0];
    assign in_val = i_s_tdata[CMD_W +: VALUE_W];

    assign full  = (r_count == CW'(STACK_DEPTH));
    assign empty = (r_count == '0);

    assign o_s_tready = (r_state == S_IDLE) && !r_skid_valid;
    assign s_take     = i_s_tvalid && o_s_tready;
    assign m_take     = r_out_valid && i_m_tready;

    assign push_min = (!empty && ($signed(r_top_min) < $signed(in_val))) ? r_top_min : in_val;

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_top_val  = r_top_val;
        n_top_min  = r_top_min;
        mem_we     = 1'b0;
        mem_wa     = r_count[AW-1:0];
        mem_wd     = '{min_value: push_min, value: in_val};
        mem_ra     = AW'(r_count - CW'(2));
        res_push   = 1'b0;
        res_status = STAT_OK;

        unique case (r_state)
            S_IDLE: begin
                if (s_take) begin
                    res_push = 1'b1;
                    case (in_cmd)
                        CMD_PUSH: begin
                            if (full) begin
                                res_status = STAT_OVERFLOW;
                            end else begin
                                mem_we    = 1'b1;
                                n_count   = r_count + CW'(1);
                                n_top_val = in_val;
                                n_top_min = push_min;
                            end
                        end
                        CMD_POP: begin
                            if (empty) begin
                                res_status = STAT_UNDERFLOW;
                            end else begin
                                n_count = r_count - CW'(1);
                                // The new top lives in memory; hold the result until the read state.
                                if (r_count != CW'(1)) begin
                                    res_push = 1'b0;
                                    n_state  = S_POP_RD;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_POP_RD: begin
                n_top_val = r_rd_data.value;
                n_top_min = r_rd_data.min_value;
                res_push  = 1'b1;
                n_state   = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase

        res.status    = res_status;
        res.is_empty  = (n_count == '0);
        res.depth     = DEPTH_W'(n_count);
        res.top_value = (n_count == '0) ? '0 : n_top_val;
        res.min_value = (n_count == '0) ? '0 : n_top_min;
    end

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        n_skid_valid = r_skid_valid;
        n_skid_data  = r_skid_data;

        if (m_take) begin
            if (r_skid_valid) begin
                n_out_data   = r_skid_data;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = 1'b0;
            end
        end

        if (res_push) begin
            if (!n_out_valid) begin
                n_out_valid = 1'b1;
                n_out_data  = res;
            end else begin
                n_skid_valid = 1'b1;
                n_skid_data  = res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top_val   <= n_top_val;
        r_top_min   <= n_top_min;
        r_out_data  <= n_out_data;
        r_skid_data <= n_skid_data;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(M_DATA_W - M_FIELDS_W){1'b0}}, r_out_data};

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(STACK_DEPTH))
        else $error("entry count exceeds stack depth");

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds a result while the output register is empty");

    a_pop_read_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP_RD) |-> $past(s_take && (in_cmd == CMD_POP)) && (r_count != '0))
        else $error("memory read state entered without a pop that leaves entries");

    a_no_overflow_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_push && (res_status == STAT_OVERFLOW)) |-> (full && !mem_we))
        else $error("overflow reported on a stack that is not full, or memory written");

    a_full_push_refused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_take && (in_cmd == CMD_PUSH) && full) |=> $stable(r_count))
        else $error("push onto a full stack changed the entry count");
`endif

endmodule

`default_nettype wire

>>> verif/testbench.sv
`default_nettype none

module testbench;

    import mts_pkg::*;

    localparam int STACK_DEPTH = 64;
    localparam int RANDOM_ITEMS = 1750;
    localparam int CALM_ITEMS = 200;
    localparam int CYCLE_LIMIT = 400000;

    // Code 3 is unassigned and must behave like a peek.
    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

    typedef enum int { PHASE_FILL, PHASE_DRAIN, PHASE_CHURN } t_phase;

    // Tracks the stack contents and the running minimum of every entry, and
    // queues the result each accepted command must produce.
    class stack_scoreboard;
        t_word value_mem[STACK_DEPTH];
        t_word floor_mem[STACK_DEPTH];
        int unsigned count;
        t_result expected_q[$];
        int errors;
        int checked;
        int overflows;
        int underflows;
        int deepest;

        function new();
            count = 0;
            errors = 0;
            checked = 0;
            overflows = 0;
            underflows = 0;
            deepest = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_command(logic [CMD_W-1:0] cmd, t_word value);
            t_result r;
            t_word floor_val;
            r.status = STAT_OK;
            if (cmd == CMD_PUSH) begin
                if (count >= STACK_DEPTH) begin
                    r.status = STAT_OVERFLOW;
                    overflows++;
                end else begin
                    floor_val = value;
                    if (count > 0 && $signed(floor_mem[count-1]) < $signed(value))
                        floor_val = floor_mem[count-1];
                    value_mem[count] = value;
                    floor_mem[count] = floor_val;
                    count++;
                end
            end else if (cmd == CMD_POP) begin
                if (count == 0) begin
                    r.status = STAT_UNDERFLOW;
                    underflows++;
                end else begin
                    count--;
                end
            end
            r.top_value = (count > 0) ? value_mem[count-1] : '0;
            r.min_value = (count > 0) ? floor_mem[count-1] : '0;
            r.depth = DEPTH_W'(count);
            r.is_empty = (count == 0);
            if (count > deepest)
                deepest = count;
            expected_q.push_back(r);
        endfunction

        function void check_result(t_result got);
            t_result exp;
            if (expected_q.size() == 0) begin
                $error("result transfer with no command outstanding");
                errors++;
                return;
            end
            exp = expected_q.pop_front();
            checked++;
            if (got.top_value !== exp.top_value) begin
                $error("top_value: expected %0d, got %0d",
                       $signed(exp.top_value), $signed(got.top_value));
                errors++;
            end
            if (got.min_value !== exp.min_value) begin
                $error("min_value: expected %0d, got %0d",
                       $signed(exp.min_value), $signed(got.min_value));
                errors++;
            end
            if (got.depth !== exp.depth) begin
                $error("depth: expected %0d, got %0d", exp.depth, got.depth);
                errors++;
            end
            if (got.is_empty !== exp.is_empty) begin
                $error("is_empty: expected %0d, got %0d", exp.is_empty, got.is_empty);
                errors++;
            end
            if (got.status !== exp.status) begin
                $error("status: expected %0d, got %0d", exp.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_s_tvalid = 1'b0;
    logic o_s_tready;
    logic [S_DATA_W-1:0] i_s_tdata = '0;
    logic o_m_tvalid;
    logic i_m_tready = 1'b0;
    logic [M_DATA_W-1:0] o_m_tdata;

    stack_scoreboard sb = new();
    int gap_pct = 0;
    int stall_pct = 0;
    int ready_hold = 0;
    int items_sent = 0;
    int cycle_count = 0;

    min_tracking_stack #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Commands are noted before results are checked, so the order of the two
    // within one edge never matters.
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_tvalid && o_s_tready)
            sb.note_command(i_s_tdata[CMD_W-1:0], i_s_tdata[CMD_W +: VALUE_W]);
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check_result(t_result'(o_m_tdata[M_FIELDS_W-1:0]));
    end

    // Result side back-pressure in random bursts.
    always @(posedge i_clk) begin
        if (ready_hold > 0) begin
            ready_hold--;
            i_m_tready <= 1'b0;
        end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
            ready_hold = $urandom_range(0, 9);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    function automatic t_word random_value();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 2)
            return t_word'($urandom_range(0, 16)) - t_word'(8);
        if (pick == 2) begin
            case ($urandom_range(0, 3))
                0: return 32'h7fff_ffff;
                1: return 32'h8000_0000;
                2: return '0;
                default: return '1;
            endcase
        end
        return $urandom;
    endfunction

    // Returns after the edge at which the command transfer completed; tvalid
    // stays high so the next call can follow without a bubble.
    task automatic send_command(logic [CMD_W-1:0] cmd, t_word value);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {{(S_DATA_W - S_FIELDS_W){1'b0}}, value, cmd};
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        items_sent++;
    endtask

    initial begin
        t_phase phase;
        int seg_len;
        int roll;
        int directed_count;
        logic [CMD_W-1:0] cmd;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty-stack corner cases, extreme values, equal minimums,
        // the unused command code, then drain past empty, push two and pop them again.
        send_command(CMD_PEEK, 32'h1234_5678);
        send_command(CMD_POP, '0);
        send_command(CMD_SPARE, '1);
        send_command(CMD_PUSH, 32'h7fff_ffff);
        send_command(CMD_PUSH, 32'h8000_0000);
        send_command(CMD_PUSH, '0);
        send_command(CMD_PEEK, '0);
        send_command(CMD_SPARE, 32'h5555_aaaa);
        send_command(CMD_PUSH, 32'h8000_0000);
        send_command(CMD_PUSH, 32'd5);
        repeat (5) send_command(CMD_POP, '1);
        send_command(CMD_POP, '0);
        send_command(CMD_PUSH, '1);
        send_command(CMD_PUSH, 32'd1);
        send_command(CMD_POP, '0);
        send_command(CMD_POP, '0);
        directed_count = items_sent;

        // Random: long push-heavy runs reach a full stack and overflow,
        // pop-heavy runs drain to underflow, churn runs mix everything.
        while (items_sent < directed_count + RANDOM_ITEMS) begin
            phase = t_phase'($urandom_range(0, 2));
            seg_len = (phase == PHASE_CHURN) ? $urandom_range(20, 80) : $urandom_range(60, 120);
            if (items_sent > directed_count + RANDOM_ITEMS - CALM_ITEMS) begin
                gap_pct = 0;
                stall_pct = 0;
            end else begin
                case ($urandom_range(0, 2))
                    0: gap_pct = 0;
                    1: gap_pct = 10;
                    default: gap_pct = 40;
                endcase
                case ($urandom_range(0, 2))
                    0: stall_pct = 0;
                    1: stall_pct = 10;
                    default: stall_pct = 40;
                endcase
            end
            repeat (seg_len) begin
                roll = $urandom_range(0, 99);
                case (phase)
                    PHASE_FILL:
                        cmd = (roll < 90) ? CMD_PUSH : (roll < 95) ? CMD_POP :
                              (roll < 98) ? CMD_PEEK : CMD_SPARE;
                    PHASE_DRAIN:
                        cmd = (roll < 90) ? CMD_POP : (roll < 95) ? CMD_PUSH :
                              (roll < 98) ? CMD_PEEK : CMD_SPARE;
                    default:
                        cmd = (roll < 45) ? CMD_PUSH : (roll < 80) ? CMD_POP :
                              (roll < 95) ? CMD_PEEK : CMD_SPARE;
                endcase
                send_command(cmd, random_value());
            end
        end
        i_s_tvalid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Sent %0d commands and checked %0d results; peak depth %0d of %0d.",
                 items_sent, sb.checked, sb.deepest, STACK_DEPTH);
        $display("Refused pushes on a full stack: %0d, refused pops on an empty one: %0d.",
                 sb.overflows, sb.underflows);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
hw/rtl/mts_pkg.sv
hw/rtl/min_tracking_stack.sv
verif/testbench.sv
